// ===== rtl/core/bsps_pkg.sv =====
// Shared types, register indexes and reset values of the bounded stepper position sequencer.
package bsps_pkg;

	// Default widths of the position count and of the tick timers.
	localparam int POSITION_BITS_DEF = 16;
	localparam int TIMER_BITS_DEF    = 18;

	// Configuration register indexes.
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_UPPER_LIMIT    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GOTO_LOW_TICKS = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_JOG_LOW_TICKS  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_WAKE_TICKS     = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SETTLE_TICKS   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_GUARD_TICKS    = 3'd5;

	// Reset values of the configuration registers.
	localparam int UPPER_LIMIT_RST    = 65535;
	localparam int GOTO_LOW_TICKS_RST = 250;
	localparam int JOG_LOW_TICKS_RST  = 1500;
	localparam int WAKE_TICKS_RST     = 2000;
	localparam int SETTLE_TICKS_RST   = 250000;
	localparam int GUARD_TICKS_RST    = 2000;

	// Command codes carried with each tick.
	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GOTO = 2'd1;
	localparam logic [MODE_W-1:0] MODE_JOG  = 2'd2;

	// Move sequencer phases.
	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_WAKE   = 6'b000010,
		PH_LOW    = 6'b000100,
		PH_HIGH   = 6'b001000,
		PH_SETTLE = 6'b010000,
		PH_GUARD  = 6'b100000
	} phase_t;

endpackage

// ===== rtl/core/bounded_stepper_position_sequencer.sv =====
// Top level of the bounded stepper position sequencer: step/dir/enable move sequencer.
//
// Every input transaction is one timing tick (nominally one microsecond) and yields exactly one
// result transaction that shows the driver pins, the position count and the busy/done status
// after that tick. A goto command (tuser 1) steps toward target_position; it is rejected at once
// with done and outcome set when the target is above upper_limit or equals the position. A jog
// command (tuser 2) steps while switch_held stays high and the bound is not reached. Each move
// raises enable, waits wake_ticks, steps, waits settle_ticks, drops enable, waits guard_ticks and
// then pulses done. Commands that arrive while a move runs are ignored. One tick is taken per
// clock cycle: the sequencer state and the result register update together on the accepting
// edge, and the result is offered from the next cycle on. A new tick is accepted in every cycle
// in which the result register is empty or its result is taken in that cycle, so the block
// sustains one transaction per cycle; a stalled result holds off the tick input. Configuration
// writes take effect from the next tick on.
module bounded_stepper_position_sequencer #(
	parameter int POSITION_BITS = bsps_pkg::POSITION_BITS_DEF,
	parameter int TIMER_BITS    = bsps_pkg::TIMER_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [bsps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [((POSITION_BITS > TIMER_BITS) ? POSITION_BITS : TIMER_BITS)-1:0] cfg_wdata,
	// Tick input.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// s_tdata from bit 0: target_position, jog_up, switch_held, zero fill.
	input  logic [((POSITION_BITS + 2 + 7) / 8) * 8 - 1:0] s_tdata,
	// s_tuser: mode.
	input  logic [bsps_pkg::MODE_W-1:0]          s_tuser,
	// Result output.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// m_tdata from bit 0: enable_pin, dir_level, step_level, position, busy_res,
	// done_res, outcome, zero fill.
	output logic [((POSITION_BITS + 6 + 7) / 8) * 8 - 1:0] m_tdata
);
	import bsps_pkg::*;

	localparam int POS_W = POSITION_BITS;
	localparam int TMR_W = TIMER_BITS;

	// Configuration registers.
	logic [POS_W-1:0] upper_limit_q;
	logic [TMR_W-1:0] goto_low_q;
	logic [TMR_W-1:0] jog_low_q;
	logic [TMR_W-1:0] wake_q;
	logic [TMR_W-1:0] settle_q;
	logic [TMR_W-1:0] guard_q;

	// Sequencer state.
	phase_t           phase_q, phase_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [POS_W-1:0] goal_q, goal_n;
	logic [TMR_W-1:0] wait_q, wait_n;
	logic             jog_q, jog_n;
	logic             dir_q, dir_n;
	logic             step_q, step_n;
	logic             awake_q, awake_n;
	logic             done_n, outcome_n;

	// Result register.
	logic             res_valid_q;
	logic             res_busy_q, res_done_q, res_outcome_q;

	// Input fields.
	logic [POS_W-1:0] target;
	logic             jog_up;
	logic             held;
	logic             accept;

	// Step decision terms.
	logic             go_up, go_down, go_goto, go;
	logic [TMR_W-1:0] low_ticks;

	assign target   = s_tdata[POS_W-1:0];
	assign jog_up   = s_tdata[POS_W];
	assign held     = s_tdata[POS_W+1];
	assign s_tready = !res_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_limit_q <= POS_W'(UPPER_LIMIT_RST);
			goto_low_q    <= TMR_W'(GOTO_LOW_TICKS_RST);
			jog_low_q     <= TMR_W'(JOG_LOW_TICKS_RST);
			wake_q        <= TMR_W'(WAKE_TICKS_RST);
			settle_q      <= TMR_W'(SETTLE_TICKS_RST);
			guard_q       <= TMR_W'(GUARD_TICKS_RST);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_UPPER_LIMIT:    upper_limit_q <= cfg_wdata[POS_W-1:0];
				REG_GOTO_LOW_TICKS: goto_low_q    <= cfg_wdata[TMR_W-1:0];
				REG_JOG_LOW_TICKS:  jog_low_q     <= cfg_wdata[TMR_W-1:0];
				REG_WAKE_TICKS:     wake_q        <= cfg_wdata[TMR_W-1:0];
				REG_SETTLE_TICKS:   settle_q      <= cfg_wdata[TMR_W-1:0];
				REG_GUARD_TICKS:    guard_q       <= cfg_wdata[TMR_W-1:0];
				default: ;
			endcase
		end
	end

	// Whether another step follows at a decision tick.
	assign go_up     = held && (pos_q < upper_limit_q);
	assign go_down   = held && (pos_q != '0) && (pos_q <= upper_limit_q);
	assign go_goto   = pos_q != goal_q;
	assign go        = jog_q ? (dir_q ? go_down : go_up) : go_goto;
	assign low_ticks = jog_q ? jog_low_q : goto_low_q;

	// Next state for one tick.
	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		goal_n    = goal_q;
		wait_n    = wait_q;
		jog_n     = jog_q;
		dir_n     = dir_q;
		step_n    = step_q;
		awake_n   = awake_q;
		done_n    = 1'b0;
		outcome_n = 1'b0;
		case (phase_q)
			PH_WAKE, PH_HIGH: begin
				if (phase_q == PH_WAKE && wait_q < wake_q) begin
					wait_n = wait_q + TMR_W'(1);
				end else if (go) begin
					if (!jog_q) begin
						dir_n = pos_q > goal_q;
					end
					phase_n = PH_LOW;
					step_n  = 1'b0;
					wait_n  = TMR_W'(1);
				end else begin
					phase_n = PH_SETTLE;
					wait_n  = '0;
				end
			end
			PH_LOW: begin
				if (wait_q < low_ticks) begin
					wait_n = wait_q + TMR_W'(1);
				end else begin
					phase_n = PH_HIGH;
					step_n  = 1'b1;
					pos_n   = dir_q ? pos_q - POS_W'(1) : pos_q + POS_W'(1);
				end
			end
			PH_SETTLE: begin
				if (wait_q < settle_q) begin
					wait_n = wait_q + TMR_W'(1);
				end else begin
					phase_n = PH_GUARD;
					awake_n = 1'b0;
					wait_n  = '0;
				end
			end
			PH_GUARD: begin
				if (wait_q < guard_q) begin
					wait_n = wait_q + TMR_W'(1);
				end else begin
					phase_n = PH_IDLE;
					done_n  = 1'b1;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				if (s_tuser == MODE_GOTO) begin
					if (target > upper_limit_q || target == pos_q) begin
						done_n    = 1'b1;
						outcome_n = 1'b1;
					end else begin
						goal_n  = target;
						jog_n   = 1'b0;
						awake_n = 1'b1;
						phase_n = PH_WAKE;
						wait_n  = '0;
					end
				end else if (s_tuser == MODE_JOG) begin
					jog_n   = 1'b1;
					dir_n   = !jog_up;
					awake_n = 1'b1;
					phase_n = PH_WAKE;
					wait_n  = '0;
				end
			end
		endcase
	end

	// State and result update on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			pos_q         <= '0;
			goal_q        <= '0;
			wait_q        <= '0;
			jog_q         <= 1'b0;
			dir_q         <= 1'b0;
			step_q        <= 1'b0;
			awake_q       <= 1'b0;
			res_valid_q   <= 1'b0;
			res_busy_q    <= 1'b0;
			res_done_q    <= 1'b0;
			res_outcome_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q       <= phase_n;
				pos_q         <= pos_n;
				goal_q        <= goal_n;
				wait_q        <= wait_n;
				jog_q         <= jog_n;
				dir_q         <= dir_n;
				step_q        <= step_n;
				awake_q       <= awake_n;
				res_busy_q    <= phase_n != PH_IDLE;
				res_done_q    <= done_n;
				res_outcome_q <= outcome_n;
				res_valid_q   <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result packing; pins and position come straight from the state registers.
	assign m_tvalid = res_valid_q;
	always_comb begin
		m_tdata              = '0;
		m_tdata[0]           = awake_q;
		m_tdata[1]           = dir_q;
		m_tdata[2]           = step_q;
		m_tdata[POS_W+2:3]   = pos_q;
		m_tdata[POS_W+3]     = res_busy_q;
		m_tdata[POS_W+4]     = res_done_q;
		m_tdata[POS_W+5]     = res_outcome_q;
	end

endmodule

// ===== rtl/core/bsps_check.sv =====
// Port-level checker for the bounded stepper position sequencer, bound to the top level.
module bsps_check #(
	parameter int POSITION_BITS = bsps_pkg::POSITION_BITS_DEF,
	parameter int TIMER_BITS    = bsps_pkg::TIMER_BITS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [((POSITION_BITS + 6 + 7) / 8) * 8 - 1:0] m_tdata
);
	import bsps_pkg::*;

	localparam int POS_W = POSITION_BITS;
	localparam int CFG_W = (POSITION_BITS > TIMER_BITS) ? POSITION_BITS : TIMER_BITS;

	logic en, busy, done, outcome;

	assign en      = m_tdata[0];
	assign busy    = m_tdata[POS_W+3];
	assign done    = m_tdata[POS_W+4];
	assign outcome = m_tdata[POS_W+5];

	// An empty result register never holds off the tick input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("tick input stalled with no pending result, cfg width %0d", CFG_W);

	// A rejection outcome only comes with a done pulse.
	a_outcome_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && outcome |-> done)
		else $error("outcome set without done");

	// Done marks the end of a sequence, so the block is no longer busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && done |-> !busy)
		else $error("done pulsed while busy");

	// The driver is only awake while a move sequence runs.
	a_enable_in_move: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && en |-> busy)
		else $error("enable high while idle");

	// A stalled result stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

endmodule

bind bounded_stepper_position_sequencer bsps_check #(
	.POSITION_BITS(POSITION_BITS),
	.TIMER_BITS(TIMER_BITS)
) u_bsps_check (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
